@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/wfmh_pkg.sv @@
// Types, constants and helpers for the filtered MurmurHash2 block.
package wfmh_pkg;

  localparam logic [31:0] MIX_MUL  = 32'd1540483477;
  localparam int          SHIFT_KEY  = 24;
  localparam int          SHIFT_TAIL = 13;
  localparam int          SHIFT_FIN  = 15;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_HASH  = 1'b1;

  // Datapath step selected by the controller for the shared multiplier.
  typedef enum logic [2:0] {
    STEP_NONE = 3'd0,
    STEP_WORD = 3'd1,
    STEP_KEY  = 3'd2,
    STEP_ACC  = 3'd3,
    STEP_TAIL = 3'd4,
    STEP_AVAL = 3'd5
  } step_t;

  typedef struct packed {
    logic  accept;
    step_t step;
    logic  load_out;
    logic  out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_hash;
    logic is_last;
    logic word_done;
  } dp_status_t;

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
  endfunction

endpackage

@@ rtl/whitespace_filtered_murmur2_hash.sv @@
// Top level of the whitespace-filtered MurmurHash2 block.
//
// Input stream: one byte per request. s_tdata carries the byte, s_tuser[0]
// the pass (0 count, 1 hash), s_tuser[1] whether the byte is present, and
// s_tlast closes the pass. The host sends the data once as a count pass and
// again as a hash pass; the seed is 1 xor the count of non-blank bytes.
// Output stream: one request per s_tlast item. m_tuser is 0 for a count
// result and 1 for a hash result; m_tdata holds the count and the hash.
// Throughput: one byte per cycle while idle; a byte that completes a 32-bit
// word holds off input while the single 32x32 multiplier mixes the word in
// three steps. A closing hash item also runs the tail and avalanche steps;
// any closing item ends in a done state that loads the result into the output
// register once it is free, and input is held off until then.
// While the output register holds a result the receiver has not taken, input
// bytes are still accepted; only the next result waits for it to drain.
// Reset clears the count, the running hash and the word buffer; a hash result
// also returns all of them to zero.
module whitespace_filtered_murmur2_hash import wfmh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [1:0]  s_tuser,   // command, has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // kept_count, hash_value
  output logic        m_tuser    // result_kind
);

  `include "assert_macros.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wfmh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  wfmh_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // a pending result is never overwritten
  `ASSERT_SAME(a_no_overwrite, clk, rst, cmd.load_out, (!m_tvalid || m_tready))
  // a completed word starts the mixing sequence next cycle
  `ASSERT_NEXT(a_word_mix, clk, rst, (cmd.accept && status.word_done), (cmd.step == STEP_WORD))
  // non-closing requests never raise a result
  `ASSERT_NEXT(a_no_spurious, clk, rst, (s_tvalid && s_tready && !s_tlast && !m_tvalid),
               !m_tvalid)
  // a closing count request holds off input until its result is posted
  `ASSERT_NEXT(a_count_busy, clk, rst, (s_tvalid && s_tready && s_tlast && !s_tuser[0]),
               !s_tready)

endmodule

@@ rtl/wfmh_datapath.sv @@
// Datapath: byte packing, counter, hash accumulator, shared multiplier, output register.
module wfmh_datapath import wfmh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  input  logic [7:0]        s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              s_tlast,
  output dp_status_t        status,
  output logic [63:0]       m_tdata,
  output logic              m_tuser
);

  logic [31:0] count;
  logic [31:0] acc;
  logic [31:0] pw;
  logic [1:0]  slot;
  logic        started;
  logic [31:0] r;

  logic        item_hash;
  logic        kept;
  logic [31:0] mul_a;
  logic [31:0] product;
  logic [31:0] fin_hash;

  assign item_hash = s_tuser[0];
  assign kept      = s_tuser[1] && !is_blank(s_tdata);

  assign status.is_hash   = item_hash;
  assign status.is_last   = s_tlast;
  assign status.word_done = item_hash && kept && (slot == 2'd3);

  always_comb begin
    case (cmd.step)
      STEP_WORD: mul_a = pw;
      STEP_KEY:  mul_a = r ^ (r >> SHIFT_KEY);
      STEP_ACC:  mul_a = acc;
      STEP_TAIL: mul_a = acc ^ pw;
      STEP_AVAL: mul_a = r ^ (r >> SHIFT_TAIL);
      default:   mul_a = pw;
    endcase
  end

  assign product  = mul_a * MIX_MUL;
  assign fin_hash = r ^ (r >> SHIFT_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      acc     <= '0;
      pw      <= '0;
      slot    <= '0;
      started <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (!item_hash) begin
          if (kept) count <= count + 32'd1;
        end else begin
          // seed fixed by the first request of the hash pass
          if (!started) begin
            acc     <= 32'd1 ^ count;
            started <= 1'b1;
          end
          if (kept) begin
            pw   <= pw | ({24'd0, s_tdata} << {slot, 3'd0});
            slot <= slot + 2'd1;
          end
        end
      end
      if (cmd.step == STEP_ACC) begin
        acc <= product ^ r;
        pw  <= '0;
      end
      if (cmd.load_out && (cmd.out_kind == KIND_HASH)) begin
        count   <= '0;
        acc     <= '0;
        pw      <= '0;
        slot    <= '0;
        started <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      STEP_WORD, STEP_KEY, STEP_AVAL: r <= product;
      STEP_TAIL: r <= (slot != 2'd0) ? product : acc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {(cmd.out_kind == KIND_HASH) ? fin_hash : 32'd0, count};
      m_tuser <= cmd.out_kind;
    end
  end

endmodule

@@ rtl/wfmh_ctrl.sv @@
// Controller: sequences word mixing, finalisation and the output handshake.
module wfmh_ctrl import wfmh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output logic       s_tready,
  output logic       m_tvalid,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_MIX_WORD = 7'b0000010,
    ST_MIX_KEY  = 7'b0000100,
    ST_MIX_ACC  = 7'b0001000,
    ST_FIN_TAIL = 7'b0010000,
    ST_FIN_AVAL = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   fin_pend;
  logic   result_kind;
  logic   accept;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cmd.accept   = accept;
    cmd.step     = STEP_NONE;
    cmd.load_out = 1'b0;
    cmd.out_kind = result_kind;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.word_done)                     state_next = ST_MIX_WORD;
          else if (status.is_last && status.is_hash) state_next = ST_FIN_TAIL;
          else if (status.is_last)                  state_next = ST_DONE;
        end
      end
      ST_MIX_WORD: begin
        cmd.step   = STEP_WORD;
        state_next = ST_MIX_KEY;
      end
      ST_MIX_KEY: begin
        cmd.step   = STEP_KEY;
        state_next = ST_MIX_ACC;
      end
      ST_MIX_ACC: begin
        cmd.step   = STEP_ACC;
        state_next = fin_pend ? ST_FIN_TAIL : ST_IDLE;
      end
      ST_FIN_TAIL: begin
        cmd.step   = STEP_TAIL;
        state_next = ST_FIN_AVAL;
      end
      ST_FIN_AVAL: begin
        cmd.step   = STEP_AVAL;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fin_pend    <= 1'b0;
      result_kind <= KIND_COUNT;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fin_pend    <= status.is_last;
        result_kind <= status.is_hash ? KIND_HASH : KIND_COUNT;
      end
      if (cmd.load_out)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the whitespace-filtered MurmurHash2 stream hasher.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfmh_pkg::*;

  localparam logic        PASS_COUNT  = 1'b0;
  localparam logic        PASS_HASH   = 1'b1;
  localparam int          ITEM_TARGET = 1750;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          DRAIN_WAIT  = 12;

  typedef struct packed {
    logic        kind;
    logic [31:0] count;
    logic [31:0] hash;
  } digest_t;

  typedef enum int unsigned {
    RDY_FULL,
    RDY_HALF,
    RDY_SPARSE,
    RDY_MOSTLY
  } ready_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  whitespace_filtered_murmur2_hash DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the hasher state
  logic [31:0] seen_count   = '0;
  logic [31:0] run_hash     = '0;
  logic [31:0] word_buf     = '0;
  logic [1:0]  word_slot    = '0;
  logic        hash_open    = 1'b0;

  digest_t     pending_digests[$];
  digest_t     due_digest;
  int          mismatch_count = 0;
  int          stream_items   = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count    = 0;
  logic [7:0]  frame_bytes[$];

  function automatic logic is_whitespace(input logic [7:0] data);
    return data == CHAR_TAB || data == CHAR_LF || data == CHAR_CR || data == CHAR_SPACE;
  endfunction

  function void predict_digest(input logic cmd, input logic [7:0] data, input logic has,
                               input logic fin);
    logic        kept;
    logic [31:0] k;
    logic [31:0] h;
    kept = has && !is_whitespace(data);
    if (cmd == PASS_COUNT) begin
      if (kept) seen_count = seen_count + 32'd1;
      if (fin) pending_digests.push_back('{KIND_COUNT, seen_count, 32'd0});
    end else begin
      // seed is fixed by the first hash request
      if (!hash_open) begin
        run_hash  = 32'd1 ^ seen_count;
        hash_open = 1'b1;
      end
      if (kept) begin
        word_buf[{word_slot, 3'b000} +: 8] = data;
        word_slot = word_slot + 2'd1;
        if (word_slot == 2'd0) begin
          k = word_buf * MIX_MUL;
          k = (k ^ (k >> SHIFT_KEY)) * MIX_MUL;
          run_hash = (run_hash * MIX_MUL) ^ k;
          word_buf = '0;
        end
      end
      if (fin) begin
        h = run_hash;
        if (word_slot != 2'd0) h = (h ^ word_buf) * MIX_MUL;
        h = (h ^ (h >> SHIFT_TAIL)) * MIX_MUL;
        h = h ^ (h >> SHIFT_FIN);
        pending_digests.push_back('{KIND_HASH, seen_count, h});
        seen_count = '0;
        run_hash   = '0;
        word_buf   = '0;
        word_slot  = '0;
        hash_open  = 1'b0;
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // One request; bursts of random length separated by random gaps
  task automatic send_request(input logic cmd, input logic [7:0] data, input logic has,
                              input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {has, cmd};
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    predict_digest(cmd, data, has, fin);
    if (has || fin) stream_items++;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] data;
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 3))
        0: data = CHAR_TAB;
        1: data = CHAR_LF;
        2: data = CHAR_CR;
        default: data = CHAR_SPACE;
      endcase
    end else begin
      data = 8'($urandom_range(0, 255));
    end
    return data;
  endfunction

  // Sends frame_bytes as one pass, with optional stray requests mixed in
  task automatic send_frame(input logic cmd, input logic stray_count);
    logic sep_close;
    int   n;
    n = frame_bytes.size();
    sep_close = (n == 0) || ($urandom_range(0, 6) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (stray_count && $urandom_range(0, 3) == 0)
        send_request(PASS_COUNT, pick_byte(), 1'b1, 1'b0);
      send_request(cmd, frame_bytes[i], 1'b1, (i == n - 1) && !sep_close);
    end
    if (sep_close) send_request(cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_empty_streams;
    send_request(PASS_COUNT, 8'h00, 1'b0, 1'b1);
    send_request(PASS_HASH, 8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_byte_extremes;
    logic [7:0] extremes[8] = '{8'h00, 8'hFF, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_SPACE,
                                8'h41, 8'h7F};
    for (int i = 0; i < 8; i++) send_request(PASS_COUNT, extremes[i], 1'b1, i == 7);
    for (int i = 0; i < 8; i++) begin
      // count request mid hash pass must leave the running hash alone
      if (i == 3) begin
        send_request(PASS_COUNT, 8'h55, 1'b1, 1'b0);
        send_request(PASS_HASH, 8'hA5, 1'b0, 1'b0);
      end
      send_request(PASS_HASH, extremes[i], 1'b1, i == 7);
    end
  endtask

  task automatic test_count_accumulation;
    send_request(PASS_COUNT, 8'h31, 1'b1, 1'b1);
    send_request(PASS_COUNT, 8'h32, 1'b1, 1'b1);
    send_request(PASS_HASH, 8'h33, 1'b1, 1'b1);
  endtask

  task automatic test_random_frames;
    int unsigned len;
    int unsigned pick;
    while (stream_items < ITEM_TARGET) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(pick_byte());
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(PASS_COUNT, 1'b0);
        send_frame(PASS_HASH, 1'b0);
      end else if (pick < 80) begin
        send_frame(PASS_COUNT, 1'b0);
        send_frame(PASS_COUNT, 1'b0);
        send_frame(PASS_HASH, 1'b0);
      end else if (pick < 85) begin
        send_frame(PASS_HASH, 1'b0);
      end else if (pick < 89) begin
        send_frame(PASS_COUNT, 1'b0);
      end else if (pick < 95) begin
        send_frame(PASS_COUNT, 1'b0);
        send_frame(PASS_HASH, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Receiver stalls in styles that change every so often
  ready_style_t ready_style = RDY_FULL;
  int unsigned  style_left  = 0;

  always @(posedge clk) begin
    if (style_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(20, 200);
    end else begin
      style_left--;
    end
    case (ready_style)
      RDY_FULL:   m_tready <= 1'b1;
      RDY_HALF:   m_tready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
      default:    m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digests.size() == 0) begin
        report_mismatch("result with nothing expected", m_tdata[31:0], '0);
      end else begin
        due_digest = pending_digests.pop_front();
        if (m_tuser !== due_digest.kind)
          report_mismatch("result_kind", {31'd0, m_tuser}, {31'd0, due_digest.kind});
        if (m_tdata[31:0] !== due_digest.count)
          report_mismatch("kept_count", m_tdata[31:0], due_digest.count);
        if (m_tdata[63:32] !== due_digest.hash)
          report_mismatch("hash_value", m_tdata[63:32], due_digest.hash);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_streams;
    test_byte_extremes;
    test_count_accumulation;
    test_random_frames;
    s_tvalid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
